>>> hw/rtl/rotation_matrix_to_quaternion_macros.svh
// Assertion macros for the rotation matrix to quaternion block.
// Used by the checker module; needs clk and rst_n in scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define RMQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmq check failed");

// Next-cycle implication, gated off during reset.
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmq check failed");

`endif

>>> hw/rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies.
`default_nettype none
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int IN_W          = 16;  // matrix element and component width
  localparam int D_W           = 17;  // sum or difference of two elements
  localparam int QB            = 15;  // quotient bits below the saturation point
  localparam int N_LANE        = 3;   // off-principal components
  localparam int Q_MAX         = 32767;
  localparam int Q_MIN         = -32768;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } br_t;

  // Control carried through the square root pipeline.
  typedef struct packed {
    logic                          valid;
    br_t                           br;
    logic [N_LANE-1:0][D_W-1:0]    d;
  } sq_ctl_t;

  // Control carried through the divider pipeline.
  typedef struct packed {
    logic                valid;
    br_t                 br;
    logic                degen;
    logic [IN_W-1:0]     prin;
    logic [N_LANE-1:0]   neg;
  } div_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/rmq_if.sv
// Channel interfaces for the rotation matrix to quaternion block.
// Depends on rmq_pkg.
`default_nettype none
interface rmq_in_if;
  import rmq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, output m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, input m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] q_w, q_x, q_y, q_z;
  logic [1:0]             branch_taken;
  logic                   degenerate;
  modport source (output valid, output q_w, q_x, q_y, q_z, branch_taken, degenerate,
                  input ready);
  modport sink   (input valid, input q_w, q_x, q_y, q_z, branch_taken, degenerate,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on rmq_pkg; control rides along with the data.
`default_nettype none
module rmq_sqrt #(
  parameter int RAD_W  = 32,
  parameter int ROOT_W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  rmq_pkg::sq_ctl_t      ctl_in,
  input  logic [RAD_W-1:0]      rad,
  output rmq_pkg::sq_ctl_t      ctl_out,
  output logic [ROOT_W-1:0]     root
);
  import rmq_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  sq_ctl_t           ctl_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    sq_ctl_t           ctl_p;
    logic [REM_W-1:0]  rem_p, cur, trial;
    logic [ROOT_W-1:0] root_p;
    logic [RAD_W-1:0]  rad_p;
    logic              ge;

    if (k == 0) begin : g_first
      assign ctl_p  = ctl_in;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad;
    end else begin : g_next
      assign ctl_p  = ctl_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
    end

    // Bring down two radicand bits, try root*4+1.
    assign cur   = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
    assign trial = REM_W'({root_p, 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k].valid <= 1'b0;
      end else if (en) begin
        ctl_r[k]  <= ctl_p;
        rem_r[k]  <= ge ? (cur - trial) : cur;
        root_r[k] <= {root_p[ROOT_W-2:0], ge};
        rad_r[k]  <= {rad_p[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign ctl_out = ctl_r[ROOT_W-1];
  assign root    = root_r[ROOT_W-1];

endmodule
`default_nettype wire

>>> hw/rtl/rmq_div.sv
// Pipelined restoring divider for the three off-principal components.
// Depends on rmq_pkg; one overflow check stage, then one quotient bit per stage.
`default_nettype none
module rmq_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 17
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  rmq_pkg::div_ctl_t                      ctl_in,
  input  logic [rmq_pkg::N_LANE-1:0][NUM_W-1:0]  numer,
  input  logic [DEN_W-1:0]                       den,
  output rmq_pkg::div_ctl_t                      ctl_out,
  output logic [rmq_pkg::N_LANE-1:0][rmq_pkg::QB-1:0] quot,
  output logic [rmq_pkg::N_LANE-1:0]             ovf
);
  import rmq_pkg::*;

  localparam int HI_W = NUM_W - QB;
  localparam int CW   = (DEN_W > HI_W) ? DEN_W : HI_W;

  div_ctl_t                           ctl_r [QB+1];
  logic [DEN_W-1:0]                   den_r [QB+1];
  logic [N_LANE-1:0][DEN_W-1:0]       rem_r [QB+1];
  logic [N_LANE-1:0][QB-1:0]          low_r [QB+1];
  logic [N_LANE-1:0][QB-1:0]          q_r   [QB+1];
  logic [N_LANE-1:0]                  ovf_r [QB+1];

  // Overflow check: quotient reaches 2^QB when the upper part is not below den.
  logic [N_LANE-1:0][CW-1:0] hi_c;
  logic [N_LANE-1:0]         ovf0;
  always_comb begin
    for (int l = 0; l < N_LANE; l++) begin
      hi_c[l] = CW'(numer[l][NUM_W-1:QB]);
      ovf0[l] = (hi_c[l] >= CW'(den));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].valid <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= ctl_in;
      den_r[0] <= den;
      ovf_r[0] <= ovf0;
      for (int l = 0; l < N_LANE; l++) begin
        rem_r[0][l] <= hi_c[l][DEN_W-1:0];
        low_r[0][l] <= numer[l][QB-1:0];
        q_r[0][l]   <= '0;
      end
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    logic [N_LANE-1:0][DEN_W:0] cur;
    logic [N_LANE-1:0]          ge;
    always_comb begin
      for (int l = 0; l < N_LANE; l++) begin
        cur[l] = {rem_r[j-1][l], low_r[j-1][l][QB-1]};
        ge[l]  = (cur[l] >= {1'b0, den_r[j-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j].valid <= 1'b0;
      end else if (en) begin
        ctl_r[j] <= ctl_r[j-1];
        den_r[j] <= den_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
        for (int l = 0; l < N_LANE; l++) begin
          rem_r[j][l] <= ge[l] ? DEN_W'(cur[l] - {1'b0, den_r[j-1]}) : cur[l][DEN_W-1:0];
          low_r[j][l] <= {low_r[j-1][l][QB-2:0], 1'b0};
          q_r[j][l]   <= {q_r[j-1][l][QB-2:0], ge[l]};
        end
      end
    end
  end

  assign ctl_out = ctl_r[QB];
  assign quot    = q_r[QB];
  assign ovf     = ovf_r[QB];

endmodule
`default_nettype wire

>>> hw/rtl/rotation_matrix_to_quaternion.sv
// Top level: 3x3 rotation matrix to unit quaternion, Shepperd's method.
// Depends on rmq_pkg, rmq_if, rmq_sqrt and rmq_div.
//
// Usage:
//  - in_ch carries one matrix per beat (m00..m22, signed, FRAC_BITS fraction
//    bits); out_ch carries one quaternion per beat (q_w..q_z, same format),
//    the branch chosen and a degenerate flag.
//  - Every input beat gives exactly one output beat, in order.
//  - Throughput: one matrix per cycle while out_ch is not stalling. The stages
//    are branch select, one stage per root bit (ROOT_W, the square root width,
//    is 16 at FRAC_BITS = 14), divider setup, overflow check,
//    15 quotient stages and the output register.
//  - The whole pipeline advances together; when out_ch stalls with a beat
//    held, every stage holds and in_ch.ready drops, so nothing is lost or
//    repeated. in_ch.ready is high whenever the output register is empty
//    or being drained.
//  - Synchronous active-low reset clears all valid bits; the pipeline comes
//    out empty and ready.
//  - A degenerate beat (square root zero, including non-rotation inputs that
//    make t negative) reports zeros for all four components.
`default_nettype none
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rmq_in_if.sink      in_ch,
  rmq_out_if.source   out_ch
);
  import rmq_pkg::*;

  // t stays below 2^FRAC_BITS + 3*2^15.
  localparam int TU    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int TS    = TU + 1;
  localparam int NW    = TU + FRAC_BITS;
  localparam int NWE   = NW + (NW % 2);
  localparam int RW    = NWE / 2;
  localparam int DEN_W = RW + 1;
  localparam int NUM_W = D_W + FRAC_BITS + 1;
  localparam int PW    = (RW + 1 > 17) ? RW + 1 : 17;
  localparam logic signed [TS-1:0] ONE_S = TS'(1) << FRAC_BITS;

  logic en;

  // ---------------- stage 0: branch select, t and the differences ----------
  logic signed [TS-1:0]  e00, e11, e22, trace_s, t_s;
  logic signed [D_W-1:0] f01, f02, f10, f12, f20, f21;
  logic [TU-1:0]         t_u;
  sq_ctl_t               s0_ctl_nxt, s0_ctl_r;
  logic [NWE-1:0]        s0_rad_nxt, s0_rad_r;

  assign e00 = TS'(in_ch.m00);
  assign e11 = TS'(in_ch.m11);
  assign e22 = TS'(in_ch.m22);
  assign f01 = D_W'(in_ch.m01);
  assign f02 = D_W'(in_ch.m02);
  assign f10 = D_W'(in_ch.m10);
  assign f12 = D_W'(in_ch.m12);
  assign f20 = D_W'(in_ch.m20);
  assign f21 = D_W'(in_ch.m21);

  always_comb begin
    trace_s          = e00 + e11 + e22;
    s0_ctl_nxt.valid = in_ch.valid;
    if (trace_s > 0) begin
      s0_ctl_nxt.br   = BR_TRACE;
      t_s             = trace_s + ONE_S;
      s0_ctl_nxt.d[0] = f21 - f12;
      s0_ctl_nxt.d[1] = f02 - f20;
      s0_ctl_nxt.d[2] = f10 - f01;
    end else if (e00 >= e11 && e00 >= e22) begin
      s0_ctl_nxt.br   = BR_X;
      t_s             = ONE_S + e00 - e11 - e22;
      s0_ctl_nxt.d[0] = f21 - f12;
      s0_ctl_nxt.d[1] = f01 + f10;
      s0_ctl_nxt.d[2] = f02 + f20;
    end else if (e11 >= e22) begin
      s0_ctl_nxt.br   = BR_Y;
      t_s             = ONE_S + e11 - e00 - e22;
      s0_ctl_nxt.d[0] = f02 - f20;
      s0_ctl_nxt.d[1] = f01 + f10;
      s0_ctl_nxt.d[2] = f12 + f21;
    end else begin
      s0_ctl_nxt.br   = BR_Z;
      t_s             = ONE_S + e22 - e11 - e00;
      s0_ctl_nxt.d[0] = f10 - f01;
      s0_ctl_nxt.d[1] = f02 + f20;
      s0_ctl_nxt.d[2] = f21 + f12;
    end
    // Clamp negative t (not a rotation) to zero.
    t_u        = t_s[TS-1] ? '0 : t_s[TU-1:0];
    s0_rad_nxt = NWE'(t_u) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r.valid <= 1'b0;
    end else if (en) begin
      s0_ctl_r <= s0_ctl_nxt;
      s0_rad_r <= s0_rad_nxt;
    end
  end

  // ---------------- square root pipeline -----------------------------------
  sq_ctl_t       sq_ctl;
  logic [RW-1:0] sq_root;

  rmq_sqrt #(
    .RAD_W  (NWE),
    .ROOT_W (RW)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (s0_ctl_r),
    .rad     (s0_rad_r),
    .ctl_out (sq_ctl),
    .root    (sq_root)
  );

  // ---------------- divider setup: principal part, numerators --------------
  logic [PW-1:0]                 prin_w;
  div_ctl_t                      pr_ctl_nxt, pr_ctl_r;
  logic [N_LANE-1:0][NUM_W-1:0]  pr_num_nxt, pr_num_r;
  logic [DEN_W-1:0]              pr_den_r;
  logic [D_W-1:0]                mag;

  always_comb begin
    prin_w           = (PW'(sq_root) + PW'(1)) >> 1;
    pr_ctl_nxt.valid = sq_ctl.valid;
    pr_ctl_nxt.br    = sq_ctl.br;
    pr_ctl_nxt.degen = (sq_root == '0);
    pr_ctl_nxt.prin  = (prin_w > PW'(Q_MAX)) ? IN_W'(Q_MAX) : prin_w[IN_W-1:0];
    mag              = '0;
    for (int l = 0; l < N_LANE; l++) begin
      pr_ctl_nxt.neg[l] = sq_ctl.d[l][D_W-1];
      mag               = sq_ctl.d[l][D_W-1] ? (~sq_ctl.d[l] + D_W'(1)) : sq_ctl.d[l];
      // d * 2^F + r, to be divided by 2r: round half away from zero.
      pr_num_nxt[l]     = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(sq_root);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_ctl_r.valid <= 1'b0;
    end else if (en) begin
      pr_ctl_r <= pr_ctl_nxt;
      pr_num_r <= pr_num_nxt;
      pr_den_r <= {sq_root, 1'b0};
    end
  end

  // ---------------- divider pipeline ---------------------------------------
  div_ctl_t                  dv_ctl;
  logic [N_LANE-1:0][QB-1:0] dv_q;
  logic [N_LANE-1:0]         dv_ovf;

  rmq_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (pr_ctl_r),
    .numer   (pr_num_r),
    .den     (pr_den_r),
    .ctl_out (dv_ctl),
    .quot    (dv_q),
    .ovf     (dv_ovf)
  );

  // ---------------- sign, saturate, place by branch ------------------------
  logic [N_LANE-1:0][IN_W-1:0] comp;
  logic [IN_W-1:0]             w_nxt, x_nxt, y_nxt, z_nxt;

  always_comb begin
    for (int l = 0; l < N_LANE; l++) begin
      if (dv_ovf[l]) begin
        comp[l] = dv_ctl.neg[l] ? IN_W'(Q_MIN) : IN_W'(Q_MAX);
      end else begin
        comp[l] = dv_ctl.neg[l] ? (~{1'b0, dv_q[l]} + IN_W'(1)) : {1'b0, dv_q[l]};
      end
    end
    case (dv_ctl.br)
      BR_TRACE: begin
        w_nxt = dv_ctl.prin; x_nxt = comp[0]; y_nxt = comp[1]; z_nxt = comp[2];
      end
      BR_X: begin
        w_nxt = comp[0]; x_nxt = dv_ctl.prin; y_nxt = comp[1]; z_nxt = comp[2];
      end
      BR_Y: begin
        w_nxt = comp[0]; x_nxt = comp[1]; y_nxt = dv_ctl.prin; z_nxt = comp[2];
      end
      default: begin
        w_nxt = comp[0]; x_nxt = comp[1]; y_nxt = comp[2]; z_nxt = dv_ctl.prin;
      end
    endcase
    // Zero root: drop all components.
    if (dv_ctl.degen) begin
      w_nxt = '0; x_nxt = '0; y_nxt = '0; z_nxt = '0;
    end
  end

  // ---------------- output register ----------------------------------------
  logic            out_v_r;
  logic [IN_W-1:0] q_w_r, q_x_r, q_y_r, q_z_r;
  br_t             br_r;
  logic            degen_r;

  // Advance the whole pipeline unless a held beat is waiting at the output.
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_ctl.valid;
      q_w_r   <= w_nxt;
      q_x_r   <= x_nxt;
      q_y_r   <= y_nxt;
      q_z_r   <= z_nxt;
      br_r    <= dv_ctl.br;
      degen_r <= dv_ctl.degen;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.q_w          = q_w_r;
  assign out_ch.q_x          = q_x_r;
  assign out_ch.q_y          = q_y_r;
  assign out_ch.q_z          = q_z_r;
  assign out_ch.branch_taken = br_r;
  assign out_ch.degenerate   = degen_r;

endmodule
`default_nettype wire

>>> hw/rtl/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion block, with bind.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_macros.svh.
`default_nettype none
`include "rotation_matrix_to_quaternion_macros.svh"
module rmq_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic signed [rmq_pkg::IN_W-1:0] q_w,
  input wire logic signed [rmq_pkg::IN_W-1:0] q_x,
  input wire logic signed [rmq_pkg::IN_W-1:0] q_y,
  input wire logic signed [rmq_pkg::IN_W-1:0] q_z,
  input wire logic [1:0]                     branch_taken,
  input wire logic                           degenerate
);
  import rmq_pkg::*;

  // A held beat keeps its payload.
  `RMQ_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(q_w) && $stable(q_x) && $stable(q_y) && $stable(q_z) && $stable(branch_taken))
  // An empty output register never blocks the input.
  `RMQ_ASSERT_NOW(a_ready, !out_valid, in_ready)
  // Degenerate beats carry zero components.
  `RMQ_ASSERT_NOW(a_degen, out_valid && degenerate, q_w == 0 && q_x == 0 && q_y == 0 && q_z == 0)
  // On the positive trace branch the principal component is non-negative.
  `RMQ_ASSERT_NOW(a_prin, out_valid && !degenerate && branch_taken == BR_TRACE, !q_w[IN_W-1])

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .q_w          (out_ch.q_w),
  .q_x          (out_ch.q_x),
  .q_y          (out_ch.q_y),
  .q_z          (out_ch.q_z),
  .branch_taken (out_ch.branch_taken),
  .degenerate   (out_ch.degenerate)
);
`default_nettype wire

>>> bench/tb_rmq_if.sv
// Testbench copy of nothing: the channel interfaces come from the RTL (rmq_if).
// This file holds the expected-result and matrix record types used by the bench.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
package tb_rmq_types_pkg;
  import rmq_pkg::*;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    br_t                br;
    logic               degen;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;
endpackage

>>> bench/tb_rotation_matrix_to_quaternion.sv
// Testbench for rotation_matrix_to_quaternion: drives matrices, predicts each
// quaternion in the bench and compares every output beat in order.
// Depends on rmq_pkg, rmq_if, tb_rmq_types_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;
  import tb_rmq_types_pkg::*;

  localparam int FB        = 14;
  localparam int LATENCY   = 35;
  localparam int N_RANDOM  = 1030;
  localparam int MAX_CYC   = 400000;
  localparam longint ONE   = 64'sd1 << FB;

  logic clk;
  logic rst_n;

  rmq_in_if  in_ch();
  rmq_out_if out_ch();

  rotation_matrix_to_quaternion #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  matrix_t pending_mats[$];   // matrices waiting to be driven
  quat_t   expected_quats[$]; // predictions waiting for their output beat
  int      fail_count = 0;
  int      cycle_count = 0;
  bit      stim_done = 1'b0;
  bit      no_idle = 1'b0;    // last part of the run: no gaps on either side
  bit      send_hold = 1'b0;  // sender pause requested by the stimulus
  bit      long_stall = 1'b0; // receiver long hold-off request

  // Append one matrix to the pending queue.
  task automatic add_pending(matrix_t mt);
    pending_mats = {pending_mats, mt};
  endtask

  // Integer square root, floor.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // d * 2^FB / (2r), nearest, ties away from zero, clipped at 65536.
  function automatic longint scale_off(longint d, longint unsigned r);
    longint unsigned mag, q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = ((mag << FB) + r) / (r << 1);
    if (q > 65536) q = 65536;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > Q_MAX) v = Q_MAX;
    if (v < Q_MIN) v = Q_MIN;
    return v[15:0];
  endfunction

  // Shepperd branch selection, root, and scaled off-diagonal terms.
  function automatic quat_t predict_quat(matrix_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, trace, t, prin;
    longint d0, d1, d2, o0, o1, o2;
    longint unsigned r;
    longint q[4];
    quat_t res;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    trace = a00 + a11 + a22;
    if (trace > 0) begin
      res.br = BR_TRACE; t = trace + ONE;
      d0 = a21 - a12; d1 = a02 - a20; d2 = a10 - a01;
    end else if (a00 >= a11 && a00 >= a22) begin
      res.br = BR_X; t = ONE + a00 - a11 - a22;
      d0 = a21 - a12; d1 = a01 + a10; d2 = a02 + a20;
    end else if (a11 >= a22) begin
      res.br = BR_Y; t = ONE + a11 - a00 - a22;
      d0 = a02 - a20; d1 = a01 + a10; d2 = a12 + a21;
    end else begin
      res.br = BR_Z; t = ONE + a22 - a11 - a00;
      d0 = a10 - a01; d1 = a02 + a20; d2 = a21 + a12;
    end
    if (t < 0) t = 0;
    r = int_sqrt(longint'(t) << FB);
    q = '{0, 0, 0, 0};
    res.degen = (r == 0);
    if (r != 0) begin
      prin = longint'((r + 1) >> 1);
      o0 = scale_off(d0, r); o1 = scale_off(d1, r); o2 = scale_off(d2, r);
      case (res.br)
        BR_TRACE: q = '{prin, o0, o1, o2};
        BR_X:     q = '{o0, prin, o1, o2};
        BR_Y:     q = '{o0, o1, prin, o2};
        default:  q = '{o0, o1, o2, prin};
      endcase
    end
    res.w = clip16(q[0]); res.x = clip16(q[1]);
    res.y = clip16(q[2]); res.z = clip16(q[3]);
    return res;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    m = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return m;
  endfunction

  // Near-rotation: elements drawn from [-16384, 16383], with one diagonal element
  // set to +ONE or -ONE in most draws, so every branch and sensible quotients are reached.
  function automatic matrix_t rot_like();
    matrix_t m;
    logic signed [15:0] mag;
    m = rand_matrix();
    mag = 16'(ONE);
    m.m01 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    m.m02 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    m.m10 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    m.m12 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    m.m20 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    m.m21 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    m.m00 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    m.m11 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    m.m22 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    case ($urandom_range(0, 3))
      0: m.m00 = mag;
      1: m.m11 = -mag;
      2: m.m22 = mag;
      default: ;
    endcase
    return m;
  endfunction

  // Sender: drive the oldest pending matrix, idle in random bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_quats = {expected_quats, predict_quat(pending_mats.pop_front())};
      end
      if (send_gap > 0) send_gap--;
      else if (!no_idle && $urandom_range(0, 15) == 0)
        send_gap = $urandom_range(1, 17);
      if (pending_mats.size() > 0 && send_gap == 0 && !send_hold) begin
        in_ch.valid <= 1'b1;
        {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
         in_ch.m20, in_ch.m21, in_ch.m22} <= pending_mats[0];
      end else if (!(in_ch.valid && !in_ch.ready)) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off when asked.
  int recv_gap = 0;
  int long_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_quats.size() == 0) begin
          $error("output beat with no prediction waiting");
          fail_count++;
        end else begin
          quat_t e;
          e = expected_quats.pop_front();
          if (out_ch.q_w !== e.w) begin
            $error("q_w expected %0d got %0d", e.w, out_ch.q_w); fail_count++;
          end
          if (out_ch.q_x !== e.x) begin
            $error("q_x expected %0d got %0d", e.x, out_ch.q_x); fail_count++;
          end
          if (out_ch.q_y !== e.y) begin
            $error("q_y expected %0d got %0d", e.y, out_ch.q_y); fail_count++;
          end
          if (out_ch.q_z !== e.z) begin
            $error("q_z expected %0d got %0d", e.z, out_ch.q_z); fail_count++;
          end
          if (out_ch.branch_taken !== e.br) begin
            $error("branch_taken expected %0d got %0d", e.br, out_ch.branch_taken);
            fail_count++;
          end
          if (out_ch.degenerate !== e.degen) begin
            $error("degenerate expected %0d got %0d", e.degen, out_ch.degenerate);
            fail_count++;
          end
        end
      end
      if (long_stall && long_left == 0) long_left = 300;
      if (long_left > 0) begin
        long_left--;
        if (long_left == 0) long_stall = 1'b0;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
        recv_gap = $urandom_range(1, 17) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYC) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    matrix_t m;
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
     in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identity, axis flips, ties, extremes, degenerate and
    // non-rotation inputs.
    m = '0; m.m00 = 16'(ONE); m.m11 = 16'(ONE); m.m22 = 16'(ONE);
    add_pending(m);
    m = '0; m.m00 = 16'(ONE); m.m11 = -16'(ONE); m.m22 = -16'(ONE);
    add_pending(m);
    m = '0; m.m00 = -16'(ONE); m.m11 = 16'(ONE); m.m22 = -16'(ONE);
    add_pending(m);
    m = '0; m.m00 = -16'(ONE); m.m11 = -16'(ONE); m.m22 = 16'(ONE);
    add_pending(m);
    m = '0; add_pending(m);                                  // tie all zero
    m = '0; m.m00 = -16'd100; m.m11 = -16'd100; m.m22 = -16'd100;
    add_pending(m);                                          // tie negative
    m = '0; m.m00 = -16'd50; m.m11 = -16'd10; m.m22 = -16'd10;
    add_pending(m);                                          // tie m11/m22
    m = '0; m.m00 = -16'sd16384; m.m11 = 16'sd0; m.m22 = 16'sd0;
    m.m01 = 16'sd5; add_pending(m);
    m = {9{16'sh8000}}; add_pending(m);
    m = {9{16'sh7fff}}; add_pending(m);
    m = {9{16'shffff}}; add_pending(m);
    m = '0; m.m00 = 16'sh8000; m.m11 = 16'sh7fff; m.m22 = 16'sh7fff;
    add_pending(m);
    m = '0; m.m00 = 16'sh7fff; m.m11 = 16'sh8000; m.m22 = 16'sh8000;
    m.m01 = 16'sh7fff; m.m10 = 16'sh7fff; m.m02 = 16'sh8000; m.m20 = 16'sh8000;
    add_pending(m);                                          // big off terms
    m = '0; m.m00 = -16'sd8192; m.m11 = -16'sd8192; m.m22 = 16'sd8192;
    m.m12 = 16'sh7fff; m.m21 = 16'sh7fff; add_pending(m);
    m = '0; m.m00 = 16'sd1; m.m11 = -16'sd20000; m.m22 = 16'sd0;
    add_pending(m);                                          // large negative m11, X branch
    m = {16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
         16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555};
    add_pending(m);
    m = ~m; add_pending(m);

    // Random: mostly rotation-like, some raw noise.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 200) begin
        // Hold the receiver off while items keep flowing in.
        long_stall = 1'b1;
      end
      if (i == 500) begin
        // Pause the sender until the pipeline drains.
        wait (pending_mats.size() == 0);
        send_hold = 1'b1;
        wait (pending_mats.size() == 0 && expected_quats.size() == 0 && !in_ch.valid);
        @(posedge clk);
        send_hold = 1'b0;
      end
      if (i == 900) no_idle = 1'b1;
      add_pending(($urandom_range(0, 3) == 0) ? rand_matrix() : rot_like());
      if (pending_mats.size() > 40) wait (pending_mats.size() < 20);
    end

    wait (pending_mats.size() == 0 && !in_ch.valid);
    wait (expected_quats.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && expected_quats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
